// ===== src/matrix_rotate_90_clockwise_defines.svh =====
// ------------------------------------------------------------------------
// Assertion macros for the matrix rotate block
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ------------------------------------------------------------------------
`ifndef MATRIX_ROTATE_90_CLOCKWISE_DEFINES_SVH
`define MATRIX_ROTATE_90_CLOCKWISE_DEFINES_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mr90_pkg.sv =====
// ------------------------------------------------------------------------
// mr90_pkg
// Sizes, state type and control structs shared by the rotate block.
// ------------------------------------------------------------------------
package mr90_pkg;

  localparam int MAX_DIM     = 8;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int DATA_W      = 32;
  localparam int SIZE_W      = 4;
  localparam int DIM_W       = $clog2(MAX_DIM + 1);
  localparam int IDX_W       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W       = 7;
  localparam int PADDR_W     = 3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_DIM);
  localparam logic [0:0]        REG_MATRIX_SIZE = 1'b0;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic load_accept;
    logic drain_start;
    logic issue;
  } ctrl_cmd_t;

  typedef struct packed {
    logic load_full;
    logic issue_last;
  } dp_status_t;

endpackage

// ===== src/mr90_ram.sv =====
// ------------------------------------------------------------------------
// mr90_ram
// Generic single-write, single-read RAM with registered read data.
// ------------------------------------------------------------------------
module mr90_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // hold read data when no read is issued
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/mr90_ctrl.sv =====
// ------------------------------------------------------------------------
// mr90_ctrl
// Load/drain state machine and output beat valid.
// ------------------------------------------------------------------------
`include "matrix_rotate_90_clockwise_defines.svh"

module mr90_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid_o,
  input  logic               out_ready,
  input  mr90_pkg::dp_status_t status_i,
  output mr90_pkg::ctrl_cmd_t  cmd_o
);
  import mr90_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_ready          = 1'b1;
        cmd_o.load_accept = in_valid;
        if (in_valid && status_i.load_full) begin
          cmd_o.drain_start = 1'b1;
          state_nxt         = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // advance only when the output register is free or being taken
        cmd_o.issue = !out_valid_r || out_ready;
        if (cmd_o.issue && status_i.issue_last) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase

    if (cmd_o.issue) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid_o = out_valid_r;

  `ASSERT_IMP(a_no_load_in_drain, state_r == ST_DRAIN, !cmd_o.load_accept, "load during drain")
  `ASSERT_NXT(a_start_enters_drain, cmd_o.drain_start, state_r == ST_DRAIN, "drain not entered")
  `ASSERT_NXT(a_issue_shows_beat, cmd_o.issue, out_valid_r, "issued read not shown")

endmodule

// ===== src/mr90_dp.sv =====
// ------------------------------------------------------------------------
// mr90_dp
// Load counter, rotation address walk, element store and last flag.
// ------------------------------------------------------------------------
`include "matrix_rotate_90_clockwise_defines.svh"

module mr90_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [mr90_pkg::DIM_W-1:0]   dim_i,
  input  logic signed [mr90_pkg::DATA_W-1:0] in_element_value,
  output logic signed [mr90_pkg::DATA_W-1:0] out_rotated_value,
  output logic                         out_last_of_matrix,
  input  mr90_pkg::ctrl_cmd_t          cmd_i,
  output mr90_pkg::dp_status_t         status_o
);
  import mr90_pkg::*;

  logic [CNT_W-1:0]  load_count_r, load_count_nxt;
  logic [CNT_W-1:0]  count_inc;
  logic [CNT_W-1:0]  total;
  logic [IDX_W-1:0]  nm1;
  logic [ADDR_W-1:0] start_addr;
  logic [IDX_W-1:0]  row_r, row_nxt;
  logic [IDX_W-1:0]  col_r, col_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic              last_r;
  logic              at_row_end;
  logic [DATA_W-1:0] rd_data;

  assign total      = CNT_W'(dim_i) * CNT_W'(dim_i);
  assign nm1        = IDX_W'(dim_i - DIM_W'(1));
  assign start_addr = ADDR_W'(total - CNT_W'(dim_i));
  assign count_inc  = load_count_r + CNT_W'(1);
  assign at_row_end = (col_r == nm1);

  assign status_o.load_full  = (count_inc >= total);
  assign status_o.issue_last = at_row_end && (row_r == nm1);

  always_comb begin
    load_count_nxt = load_count_r;
    if (cmd_i.load_accept) begin
      load_count_nxt = status_o.load_full ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_count_r <= '0;
    end else begin
      load_count_r <= load_count_nxt;
    end
  end

  // walk up each source column: step back by N, then move to the next column
  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    addr_nxt = addr_r;
    base_nxt = base_r;
    if (cmd_i.drain_start) begin
      row_nxt  = '0;
      col_nxt  = '0;
      addr_nxt = start_addr;
      base_nxt = start_addr;
    end else if (cmd_i.issue) begin
      if (at_row_end) begin
        row_nxt  = row_r + IDX_W'(1);
        col_nxt  = '0;
        addr_nxt = base_r + ADDR_W'(1);
        base_nxt = base_r + ADDR_W'(1);
      end else begin
        col_nxt  = col_r + IDX_W'(1);
        addr_nxt = addr_r - ADDR_W'(dim_i);
      end
    end
  end

  always_ff @(posedge clk) begin
    row_r  <= row_nxt;
    col_r  <= col_nxt;
    addr_r <= addr_nxt;
    base_r <= base_nxt;
    if (cmd_i.issue) begin
      last_r <= status_o.issue_last;
    end
  end

  mr90_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd_i.load_accept),
    .wr_addr (load_count_r[ADDR_W-1:0]),
    .wr_data (in_element_value),
    .rd_en   (cmd_i.issue),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  assign out_rotated_value  = rd_data;
  assign out_last_of_matrix = last_r;

  `ASSERT_IMP(a_count_in_store, 1'b1, load_count_r < CNT_W'(STORE_DEPTH), "load count overran")
  `ASSERT_IMP(a_walk_in_range, cmd_i.issue, (col_r <= nm1) && (row_r <= nm1), "walk out of range")

endmodule

// ===== src/matrix_rotate_90_clockwise.sv =====
// ------------------------------------------------------------------------
// matrix_rotate_90_clockwise
// Loads an N x N matrix in row-major order and streams it out rotated
// 90 degrees clockwise: out[r][c] = in[N-1-c][r].
// ------------------------------------------------------------------------
// Usage:
//   Input beats (in_valid/in_ready) carry one element each, row-major.
//   in_ready is high while loading, so an element is taken whenever offered.
//   After the N*N-th element the block drains: in_ready drops and the
//   rotated matrix leaves on out_valid/out_ready, one beat per cycle while
//   the receiver takes them, with out_last_of_matrix set on the final beat.
//   out_valid rises once the controller has entered the drain state and
//   issued the first store read, both registered; loading and draining of a
//   matrix alternate, set by the load/drain state machine, so no element is
//   taken while a matrix drains.
//   A stalled receiver holds the output register and pauses the drain.
//   Loading of the next matrix resumes once the final read is issued,
//   even while the final beat still waits to be taken.
//   matrix_size (APB byte address 0) sets N; 0 acts as 1, values above 8
//   act as 8. Write it only while idle. Reset sets N to 8 and clears the
//   load counter; the store needs no clearing pass.
// ------------------------------------------------------------------------
module matrix_rotate_90_clockwise (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [mr90_pkg::DATA_W-1:0]  in_element_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mr90_pkg::DATA_W-1:0]  out_rotated_value,
  output logic                                out_last_of_matrix,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [mr90_pkg::PADDR_W-1:0]        cfg_paddr,
  input  logic [31:0]                         cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);
  import mr90_pkg::*;

  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [DIM_W-1:0]  dim;
  logic              reg_hit;
  ctrl_cmd_t         cmd;
  dp_status_t        status;

  assign cfg_pready = 1'b1;
  assign reg_hit    = (cfg_paddr[PADDR_W-1:2] == REG_MATRIX_SIZE);

  always_comb begin
    size_nxt = size_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && reg_hit) begin
      size_nxt = cfg_pwdata[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else begin
      size_r <= size_nxt;
    end
  end

  assign cfg_prdata = reg_hit ? {{(32-SIZE_W){1'b0}}, size_r} : '0;

  // clamp the side length into 1..MAX_DIM
  always_comb begin
    if (size_r == '0) begin
      dim = DIM_W'(1);
    end else if (size_r > SIZE_W'(MAX_DIM)) begin
      dim = DIM_W'(MAX_DIM);
    end else begin
      dim = DIM_W'(size_r);
    end
  end

  mr90_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid_o (out_valid),
    .out_ready   (out_ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mr90_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .dim_i              (dim),
    .in_element_value   (in_element_value),
    .out_rotated_value  (out_rotated_value),
    .out_last_of_matrix (out_last_of_matrix),
    .cmd_i              (cmd),
    .status_o           (status)
  );

endmodule

// ===== tb/matrix_rotate_90_clockwise_tb.sv =====
// ------------------------------------------------------------------------
// matrix_rotate_90_clockwise_tb
// Loads square matrices of assorted sizes through the element channel and
// checks every rotated beat against an in-bench model of the store and the
// load counter. A directed table covers size limits, register decoding and
// size changes in the middle of a load. Random matrices follow, under
// several sender and receiver idle patterns.
// ------------------------------------------------------------------------
module matrix_rotate_90_clockwise_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mr90_pkg::*;

  localparam logic [PADDR_W-1:0] MATRIX_SIZE_ADDR = {REG_MATRIX_SIZE, 2'b00};
  localparam logic [PADDR_W-1:0] UNMAPPED_ADDR    = PADDR_W'(4);
  localparam int RANDOM_ITEMS   = 380;
  localparam int DRAIN_SETTLE   = 8;
  localparam int NUM_DIR_ROWS   = 32;

  typedef enum logic {
    ROW_CFG,
    ROW_ELEM
  } row_kind_t;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } rotated_beat_t;

  typedef struct {
    row_kind_t                kind;
    logic [PADDR_W-1:0]       addr;
    logic [31:0]              data;
    bit                       typed;
    logic signed [DATA_W-1:0] want_value;
    logic                     want_last;
  } row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [DATA_W-1:0] in_element_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_rotated_value;
  logic                     out_last_of_matrix;
  logic                     cfg_psel = 1'b0;
  logic                     cfg_penable = 1'b0;
  logic                     cfg_pwrite = 1'b0;
  logic [PADDR_W-1:0]       cfg_paddr = '0;
  logic [31:0]              cfg_pwdata = '0;
  logic [31:0]              cfg_prdata;
  logic                     cfg_pready;

  // mirror of the block state
  logic [DATA_W-1:0]  store_mirror [STORE_DEPTH];
  logic [CNT_W-1:0]   fill_count = '0;
  logic [SIZE_W-1:0]  size_reg = SIZE_RESET;

  rotated_beat_t drain_calc_q [$];
  rotated_beat_t rotated_due_q [$];

  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int items_sent = 0;

  row_t dir_rows [NUM_DIR_ROWS] = '{
    '{ROW_CFG,  MATRIX_SIZE_ADDR, 32'd1,         1'b0, '0,            1'b0},
    '{ROW_ELEM, '0,               32'h7FFF_FFFF, 1'b1, 32'sh7FFF_FFFF, 1'b1},
    '{ROW_ELEM, '0,               32'h8000_0000, 1'b1, 32'sh8000_0000, 1'b1},
    '{ROW_ELEM, '0,               32'h0000_0000, 1'b1, 32'sh0000_0000, 1'b1},
    '{ROW_ELEM, '0,               32'hFFFF_FFFF, 1'b1, 32'shFFFF_FFFF, 1'b1},
    // size zero acts as one
    '{ROW_CFG,  MATRIX_SIZE_ADDR, 32'd0,         1'b0, '0,            1'b0},
    '{ROW_ELEM, '0,               32'h5A5A_5A5A, 1'b1, 32'sh5A5A_5A5A, 1'b1},
    // unmapped register: size stays one
    '{ROW_CFG,  UNMAPPED_ADDR,    32'd3,         1'b0, '0,            1'b0},
    '{ROW_ELEM, '0,               32'hA5A5_A5A5, 1'b1, 32'shA5A5_A5A5, 1'b1},
    // upper write bits drop, size two
    '{ROW_CFG,  MATRIX_SIZE_ADDR, 32'hFFFF_FFF2, 1'b0, '0,            1'b0},
    '{ROW_ELEM, '0,               32'd1,         1'b0, '0,            1'b0},
    '{ROW_ELEM, '0,               32'd2,         1'b0, '0,            1'b0},
    '{ROW_ELEM, '0,               32'd3,         1'b0, '0,            1'b0},
    '{ROW_ELEM, '0,               32'd4,         1'b0, '0,            1'b0},
    // shrink mid-load: five loaded at size three, next one emits at size two
    '{ROW_CFG,  MATRIX_SIZE_ADDR, 32'd3,         1'b0, '0,            1'b0},
    '{ROW_ELEM, '0,               32'd11,        1'b0, '0,            1'b0},
    '{ROW_ELEM, '0,               32'd12,        1'b0, '0,            1'b0},
    '{ROW_ELEM, '0,               32'd13,        1'b0, '0,            1'b0},
    '{ROW_ELEM, '0,               32'd14,        1'b0, '0,            1'b0},
    '{ROW_ELEM, '0,               32'd15,        1'b0, '0,            1'b0},
    '{ROW_CFG,  MATRIX_SIZE_ADDR, 32'd2,         1'b0, '0,            1'b0},
    '{ROW_ELEM, '0,               32'd16,        1'b0, '0,            1'b0},
    // grow mid-load: three loaded at size two, finish at size three
    '{ROW_ELEM, '0,               32'd21,        1'b0, '0,            1'b0},
    '{ROW_ELEM, '0,               32'd22,        1'b0, '0,            1'b0},
    '{ROW_ELEM, '0,               32'd23,        1'b0, '0,            1'b0},
    '{ROW_CFG,  MATRIX_SIZE_ADDR, 32'd3,         1'b0, '0,            1'b0},
    '{ROW_ELEM, '0,               32'd24,        1'b0, '0,            1'b0},
    '{ROW_ELEM, '0,               32'd25,        1'b0, '0,            1'b0},
    '{ROW_ELEM, '0,               32'd26,        1'b0, '0,            1'b0},
    '{ROW_ELEM, '0,               32'd27,        1'b0, '0,            1'b0},
    '{ROW_ELEM, '0,               32'd28,        1'b0, '0,            1'b0},
    '{ROW_ELEM, '0,               32'd29,        1'b0, '0,            1'b0}
  };

  matrix_rotate_90_clockwise u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_element_value   (in_element_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_rotated_value  (out_rotated_value),
    .out_last_of_matrix (out_last_of_matrix),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready)
  );

  always #2 clk = ~clk;

  function automatic int eff_side();
    if (size_reg == '0) begin
      return 1;
    end
    if (size_reg > MAX_DIM) begin
      return MAX_DIM;
    end
    return int'(size_reg);
  endfunction

  // Store one element; on a full matrix queue the rotated beats.
  function automatic void predict_rotation(input logic [DATA_W-1:0] v);
    int n;
    int total;
    int idx;
    int k;
    n = eff_side();
    total = n * n;
    if (fill_count < STORE_DEPTH) begin
      store_mirror[fill_count] = v;
    end
    fill_count = fill_count + 1'b1;
    if (fill_count < total) begin
      return;
    end
    fill_count = '0;
    k = 0;
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        idx = ((n - 1 - c) * n + r) % STORE_DEPTH;
        drain_calc_q.push_back(rotated_beat_t'{store_mirror[idx], k == total - 1});
        k++;
      end
    end
  endfunction

  function automatic void set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      IDLE_SEND: begin
        send_gap_pct = 54;
        recv_stall_pct = 0;
      end
      IDLE_RECV: begin
        send_gap_pct = 0;
        recv_stall_pct = 54;
      end
      default: begin
        send_gap_pct = 23;
        recv_stall_pct = 23;
      end
    endcase
  endfunction

  task automatic log_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  // Drive one element beat and hold it until taken.
  task automatic send_element(input logic [DATA_W-1:0] v, input bit typed,
                              input logic signed [DATA_W-1:0] tv, input logic tl);
    rotated_beat_t b;
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid <= 1'b1;
    in_element_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_rotation(v);
    while (drain_calc_q.size() != 0) begin
      b = drain_calc_q.pop_front();
      if (typed) begin
        b.value = tv;
        b.last = tl;
      end
      rotated_due_q.push_back(b);
    end
    items_sent++;
  endtask

  // Wait for the drain to finish, then do one APB write.
  task automatic write_reg(input logic [PADDR_W-1:0] a, input logic [31:0] d);
    in_valid <= 1'b0;
    while (rotated_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_SETTLE) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= a;
    cfg_pwdata <= d;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (a[PADDR_W-1:2] == REG_MATRIX_SIZE) begin
      size_reg = d[SIZE_W-1:0];
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Check taken result beats; pick the next stall.
  always @(posedge clk) begin
    rotated_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (rotated_due_q.size() == 0) begin
        log_failure($sformatf("unexpected beat: value %0d last %0b",
                              out_rotated_value, out_last_of_matrix));
      end else begin
        want = rotated_due_q.pop_front();
        if (out_rotated_value !== want.value || out_last_of_matrix !== want.last) begin
          log_failure($sformatf("mismatch: expected value %0d last %0b, got value %0d last %0b",
                                want.value, want.last, out_rotated_value,
                                out_last_of_matrix));
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    logic [DATA_W-1:0] extremes [4];
    logic [31:0]       wdata;
    int                sel;
    int                total;
    int                split;
    int                k;
    int                mat_idx;
    extremes = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
    set_idle(IDLE_NONE);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_reg(dir_rows[i].addr, dir_rows[i].data);
      end else begin
        send_element(dir_rows[i].data, dir_rows[i].typed, dir_rows[i].want_value,
                     dir_rows[i].want_last);
      end
    end

    items_sent = 0;
    mat_idx = 0;
    while (items_sent < RANDOM_ITEMS) begin
      set_idle(idle_mode_t'((mat_idx / 2) % 4));
      wdata = $urandom();
      sel = $urandom_range(99);
      if (sel < 8) begin
        wdata[SIZE_W-1:0] = '0;
      end else if (sel < 16) begin
        wdata[SIZE_W-1:0] = SIZE_W'($urandom_range(MAX_DIM + 1, 15));
      end else begin
        wdata[SIZE_W-1:0] = SIZE_W'($urandom_range(1, $urandom_range(1, MAX_DIM)));
      end
      write_reg(MATRIX_SIZE_ADDR, wdata);
      if ($urandom_range(99) < 5) begin
        write_reg(UNMAPPED_ADDR, $urandom());
      end
      total = eff_side() * eff_side();
      split = 0;
      if (total > 1 && $urandom_range(99) < 20) begin
        split = $urandom_range(1, total - 1);
      end
      k = 0;
      do begin
        if ($urandom_range(99) < 10) begin
          send_element(extremes[$urandom_range(3)], 1'b0, '0, 1'b0);
        end else begin
          send_element($urandom(), 1'b0, '0, 1'b0);
        end
        k++;
        // change the size part way through the load
        if (k == split) begin
          wdata = $urandom();
          wdata[SIZE_W-1:0] = SIZE_W'($urandom_range(0, 15));
          write_reg(MATRIX_SIZE_ADDR, wdata);
        end
      end while (fill_count != '0);
      mat_idx++;
    end

    in_valid <= 1'b0;
    while (rotated_due_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && rotated_due_q.size() == 0) begin
      $display("matrix_rotate_90_clockwise_tb passed");
    end else begin
      $display("matrix_rotate_90_clockwise_tb failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("matrix_rotate_90_clockwise_tb failed");
    $finish;
  end

endmodule
